// ===== rtl/playfair_digram_cipher_assert.svh =====
// Assertion macros for the Playfair digram cipher.
// Each check is clocked on the rising edge and is switched off while reset is high.
`ifndef PLAYFAIR_DIGRAM_CIPHER_ASSERT_SVH
`define PLAYFAIR_DIGRAM_CIPHER_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define PFC_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define PFC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define PFC_ASSERT_SAME(label, clk, rst, ante, cons, msg)
`define PFC_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

// ===== rtl/pfc_pkg.sv =====
`default_nettype none

package pfc_pkg;

  localparam int Side        = 5;
  localparam int LetterW     = 5;
  localparam int LetterCount = 26;
  localparam int RegW        = 60;
  localparam int PosW        = 3;

  localparam logic [LetterW-1:0] PadLetter = 5'd25;

  // Configuration register indexes.
  localparam logic [1:0] RegCellsLow = 2'd0;
  localparam logic [1:0] RegCellsMid = 2'd1;
  localparam logic [1:0] RegCellLast = 2'd2;
  localparam logic [1:0] RegDir      = 2'd3;

  typedef logic [LetterW-1:0] letter_t;
  typedef logic [PosW-1:0]    pos_t;

  // Key square, indexed [row][col].
  typedef logic [Side-1:0][Side-1:0][LetterW-1:0] square_t;

  // Where one lane found its letter.
  typedef struct packed {
    logic found;
    pos_t row;
    pos_t col;
  } loc_t;

  // Step one place along a row or column, wrapping at the edge.
  function automatic pos_t shift_pos(input pos_t p, input logic back);
    pos_t res;
    if (back) begin
      res = (p == '0) ? pos_t'(Side - 1) : p - pos_t'(1);
    end else begin
      res = (p == pos_t'(Side - 1)) ? '0 : p + pos_t'(1);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/playfair_digram_cipher.sv =====
`default_nettype none
// Playfair digram substitution. One letter pair is taken at each rising edge with
// start high and busy low, so a text stream runs at one pair per clock; busy is only
// high during reset. The result beat is registered after the pair is taken:
// one register stage after the two letter-search lanes, one after the merge that
// picks the substituted cells. done is high for exactly one cycle per beat and the
// receiver cannot stall it, so out_first, out_second and letter_error must be
// captured on that edge. letter_error flags a letter missing from the key square
// (J, say, or any code above 25); both letters then read as zero. Load the square
// and direction through the write port only while no pair is in flight.

`include "playfair_digram_cipher_assert.svh"

module playfair_digram_cipher (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         start,
  output logic                        busy,
  input  wire pfc_pkg::letter_t       first_letter,
  input  wire pfc_pkg::letter_t       second_letter,
  input  wire                         pad_second,
  output logic                        done,
  output pfc_pkg::letter_t            out_first,
  output pfc_pkg::letter_t            out_second,
  output logic                        letter_error,
  input  wire                         cfg_write,
  input  wire [1:0]                   cfg_index,
  input  wire [pfc_pkg::RegW-1:0]     cfg_data
);

  // Configuration registers.
  logic [pfc_pkg::RegW-1:0] cells_low;
  logic [pfc_pkg::RegW-1:0] cells_mid;
  pfc_pkg::letter_t         cell_last;
  logic                     direction;

  pfc_pkg::square_t square;
  logic             accept;
  pfc_pkg::letter_t letter_b;
  pfc_pkg::loc_t    lane_a, lane_b;

  // Lane results held for the merge stage.
  logic          s1_valid;
  pfc_pkg::loc_t loc_a, loc_b;

  // Hold off only while in reset; every other cycle takes a beat.
  assign busy   = rst;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      cells_low <= '0;
      cells_mid <= '0;
      cell_last <= '0;
      direction <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        pfc_pkg::RegCellsLow: cells_low <= cfg_data;
        pfc_pkg::RegCellsMid: cells_mid <= cfg_data;
        pfc_pkg::RegCellLast: cell_last <= cfg_data[pfc_pkg::LetterW-1:0];
        pfc_pkg::RegDir:      direction <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Unpack the row-major cell registers into the square view.
  always_comb begin
    for (int r = 0; r < pfc_pkg::Side; r++) begin
      for (int c = 0; c < pfc_pkg::Side; c++) begin
        if (r * pfc_pkg::Side + c < 12) begin
          square[r][c] = cells_low[(r * pfc_pkg::Side + c) * pfc_pkg::LetterW +: pfc_pkg::LetterW];
        end else if (r * pfc_pkg::Side + c < 24) begin
          square[r][c] =
            cells_mid[(r * pfc_pkg::Side + c - 12) * pfc_pkg::LetterW +: pfc_pkg::LetterW];
        end else begin
          square[r][c] = cell_last;
        end
      end
    end
  end

  // Pad the missing second letter with Z, but only when encrypting.
  assign letter_b = (!direction && pad_second) ? pfc_pkg::PadLetter : second_letter;

  pfc_lane u_lane_a (
    .letter (first_letter),
    .square (square),
    .loc    (lane_a)
  );

  pfc_lane u_lane_b (
    .letter (letter_b),
    .square (square),
    .loc    (lane_b)
  );

  // Advance the lane results one stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    loc_a <= lane_a;
    loc_b <= lane_b;
  end

  pfc_merge u_merge (
    .clk          (clk),
    .rst          (rst),
    .valid        (s1_valid),
    .loc_a        (loc_a),
    .loc_b        (loc_b),
    .square       (square),
    .back         (direction),
    .done         (done),
    .out_first    (out_first),
    .out_second   (out_second),
    .letter_error (letter_error)
  );

  `PFC_ASSERT_NEXT(a_accept_to_s1, clk, rst, accept, s1_valid, "accepted pair lost in lane stage")
  `PFC_ASSERT_NEXT(a_s1_to_done, clk, rst, s1_valid, done, "lane stage beat did not reach output")
  `PFC_ASSERT_NEXT(a_found_no_error, clk, rst, s1_valid && loc_a.found && loc_b.found, done && !letter_error, "error raised with both letters found")
  `PFC_ASSERT_SAME(a_error_zero, clk, rst, done && letter_error, out_first == '0 && out_second == '0, "error beat carries nonzero letters")

endmodule

`default_nettype wire

// ===== rtl/pfc_lane.sv =====
`default_nettype none

// Locate one letter in the key square; the highest-numbered matching cell wins.
module pfc_lane (
  input  wire pfc_pkg::letter_t letter,
  input  wire pfc_pkg::square_t square,
  output pfc_pkg::loc_t         loc
);

  logic in_range;

  assign in_range = (letter < pfc_pkg::letter_t'(pfc_pkg::LetterCount));

  always_comb begin
    loc = '0;
    for (int r = 0; r < pfc_pkg::Side; r++) begin
      for (int c = 0; c < pfc_pkg::Side; c++) begin
        if (in_range && (square[r][c] == letter)) begin
          loc.found = 1'b1;
          loc.row   = pfc_pkg::pos_t'(r);
          loc.col   = pfc_pkg::pos_t'(c);
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/pfc_merge.sv =====
`default_nettype none

// Combine both lane locations into the substituted pair and register the result beat.
module pfc_merge (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   valid,
  input  wire pfc_pkg::loc_t    loc_a,
  input  wire pfc_pkg::loc_t    loc_b,
  input  wire pfc_pkg::square_t square,
  input  wire                   back,
  output logic                  done,
  output pfc_pkg::letter_t      out_first,
  output pfc_pkg::letter_t      out_second,
  output logic                  letter_error
);

  logic          same_row;
  logic          same_col;
  logic          both_found;
  pfc_pkg::pos_t ta_row, ta_col, tb_row, tb_col;

  assign same_row   = (loc_a.row == loc_b.row);
  assign same_col   = (loc_a.col == loc_b.col);
  assign both_found = loc_a.found && loc_b.found;

  always_comb begin
    if (same_row) begin
      ta_row = loc_a.row;
      ta_col = pfc_pkg::shift_pos(loc_a.col, back);
      tb_row = loc_b.row;
      tb_col = pfc_pkg::shift_pos(loc_b.col, back);
    end else if (same_col) begin
      ta_row = pfc_pkg::shift_pos(loc_a.row, back);
      ta_col = loc_a.col;
      tb_row = pfc_pkg::shift_pos(loc_b.row, back);
      tb_col = loc_b.col;
    end else begin
      ta_row = loc_a.row;
      ta_col = loc_b.col;
      tb_row = loc_b.row;
      tb_col = loc_a.col;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= valid;
    end
  end

  always_ff @(posedge clk) begin
    out_first    <= both_found ? square[ta_row][ta_col] : '0;
    out_second   <= both_found ? square[tb_row][tb_col] : '0;
    letter_error <= !both_found;
  end

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import pfc_pkg::*;

  // Two register stages between an accepted pair and its result beat.
  localparam int PipeDepth = 2;
  localparam int CellCount = Side * Side;
  localparam int CellsPerReg = 12;
  localparam int TopCode = (1 << LetterW) - 1;
  localparam logic DirEncrypt = 1'b0;
  localparam logic DirDecrypt = 1'b1;

  typedef struct packed {
    letter_t first;
    letter_t second;
    logic    error;
  } digram_t;

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            start = 1'b0;
  logic            busy;
  letter_t         first_letter = '0;
  letter_t         second_letter = '0;
  logic            pad_second = 1'b0;
  logic            done;
  letter_t         out_first;
  letter_t         out_second;
  logic            letter_error;
  logic            cfg_write = 1'b0;
  logic [1:0]      cfg_index = '0;
  logic [RegW-1:0] cfg_data = '0;

  // Mirror of the key square and direction as the block should hold them.
  letter_t key_cells [CellCount];
  logic    decrypt_mode;

  // Square about to be loaded; random letters are mostly drawn from it.
  letter_t square_plan [CellCount];

  // Substituted pairs still owed by the block, oldest first.
  digram_t expected_digrams [$];

  bit idle_on = 1'b1;
  int pairs_sent = 0;
  int results_seen = 0;
  int flagged_count = 0;
  int mismatch_count = 0;
  int settings_loaded = 0;

  playfair_digram_cipher i_dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .first_letter  (first_letter),
    .second_letter (second_letter),
    .pad_second    (pad_second),
    .done          (done),
    .out_first     (out_first),
    .out_second    (out_second),
    .letter_error  (letter_error),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // 12 ns period.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic letter_t ltr(byte c);
    return letter_t'(c - "A");
  endfunction

  // Highest-numbered cell holding the letter wins; codes above Z never match.
  function automatic int locate_letter(letter_t l);
    int hit;
    hit = -1;
    if (l < LetterCount) begin
      for (int k = 0; k < CellCount; k++) begin
        if (key_cells[k] == l) hit = k;
      end
    end
    return hit;
  endfunction

  function automatic int wrap_step(int p, logic back);
    return back ? (p + Side - 1) % Side : (p + 1) % Side;
  endfunction

  // Substitute one pair with the mirrored square and direction.
  function automatic digram_t predict_digram(letter_t a, letter_t b, logic pad);
    digram_t res;
    int ka, kb, ar, ac, br, bc;
    res = '0;
    // The pad only stands in for a missing second letter when encrypting.
    if (decrypt_mode == DirEncrypt && pad) b = PadLetter;
    ka = locate_letter(a);
    kb = locate_letter(b);
    if (ka < 0 || kb < 0) begin
      res.error = 1'b1;
      return res;
    end
    ar = ka / Side;
    ac = ka % Side;
    br = kb / Side;
    bc = kb % Side;
    // Same row is tested first, so identical letters slide along their row.
    if (ar == br) begin
      res.first  = key_cells[ar * Side + wrap_step(ac, decrypt_mode)];
      res.second = key_cells[br * Side + wrap_step(bc, decrypt_mode)];
    end else if (ac == bc) begin
      res.first  = key_cells[wrap_step(ar, decrypt_mode) * Side + ac];
      res.second = key_cells[wrap_step(br, decrypt_mode) * Side + bc];
    end else begin
      res.first  = key_cells[ar * Side + bc];
      res.second = key_cells[br * Side + ac];
    end
    return res;
  endfunction

  function automatic void plan_alphabet(letter_t omit);
    int n;
    n = 0;
    for (int l = 0; l < LetterCount; l++) begin
      if (l != omit) begin
        square_plan[n] = letter_t'(l);
        n++;
      end
    end
  endfunction

  function automatic void shuffle_plan();
    letter_t t;
    int j;
    for (int i = CellCount - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = square_plan[i];
      square_plan[i] = square_plan[j];
      square_plan[j] = t;
    end
  endfunction

  function automatic void fill_plan(letter_t v);
    foreach (square_plan[k]) square_plan[k] = v;
  endfunction

  // Any 5-bit code per cell: repeated letters and unmatched codes galore.
  function automatic void scramble_plan();
    foreach (square_plan[k]) square_plan[k] = letter_t'($urandom_range(0, TopCode));
  endfunction

  function automatic letter_t pick_letter();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return square_plan[$urandom_range(0, CellCount - 1)];
    if (r < 92) return letter_t'($urandom_range(0, LetterCount - 1));
    return letter_t'($urandom_range(LetterCount, TopCode));
  endfunction

  // Hold start low until every owed beat is back, then let the pipe settle.
  task automatic drain_pairs();
    @(negedge clk);
    start = 1'b0;
    while (expected_digrams.size() != 0) @(negedge clk);
    repeat (PipeDepth + 2) @(negedge clk);
  endtask

  // One register write; mirror it at the edge that takes it.
  task automatic write_reg(logic [1:0] idx, logic [RegW-1:0] data);
    @(negedge clk);
    start = 1'b0;
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(posedge clk);
    case (idx)
      RegCellsLow: begin
        for (int i = 0; i < CellsPerReg; i++) key_cells[i] = data[LetterW * i +: LetterW];
      end
      RegCellsMid: begin
        for (int i = 0; i < CellsPerReg; i++) begin
          key_cells[CellsPerReg + i] = data[LetterW * i +: LetterW];
        end
      end
      RegCellLast: begin
        key_cells[CellCount - 1] = data[LetterW - 1:0];
      end
      RegDir: begin
        decrypt_mode = data[0];
      end
      default: ;
    endcase
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  // Drain, then load the planned square and a direction. Unused upper bits of
  // the narrow registers carry noise, which the block must drop.
  task automatic load_plan(logic dir);
    logic [RegW-1:0] low_bits, mid_bits, noise;
    drain_pairs();
    for (int i = 0; i < CellsPerReg; i++) begin
      low_bits[LetterW * i +: LetterW] = square_plan[i];
      mid_bits[LetterW * i +: LetterW] = square_plan[CellsPerReg + i];
    end
    write_reg(RegCellsLow, low_bits);
    write_reg(RegCellsMid, mid_bits);
    noise = RegW'({$urandom, $urandom});
    noise[LetterW - 1:0] = square_plan[CellCount - 1];
    write_reg(RegCellLast, noise);
    noise = RegW'({$urandom, $urandom});
    noise[0] = dir;
    write_reg(RegDir, noise);
    settings_loaded++;
  endtask

  // Send one pair after a random gap. start is left high on return; the next
  // call either raises a new beat or drops it at the next falling edge.
  task automatic send_digram(letter_t a, letter_t b, logic pad);
    int gap;
    gap = idle_on ? $urandom_range(0, 9) : 0;
    repeat (gap) begin
      @(negedge clk);
      start = 1'b0;
    end
    @(negedge clk);
    start = 1'b1;
    first_letter = a;
    second_letter = b;
    pad_second = pad;
    do @(posedge clk); while (busy !== 1'b0);
    expected_digrams.push_back(predict_digram(a, b, pad));
    pairs_sent++;
  endtask

  // Square straight out of reset: every cell is A, so A sits at the last cell.
  task automatic test_reset_square();
    send_digram(ltr("A"), ltr("A"), 1'b0);
    send_digram(ltr("A"), ltr("B"), 1'b0);
    send_digram(ltr("A"), ltr("A"), 1'b1);
    send_digram(letter_t'(TopCode), ltr("A"), 1'b0);
  endtask

  // Classic square without J, encrypting: row, column, rectangle, wraps, pad.
  task automatic test_standard_encrypt();
    plan_alphabet(ltr("J"));
    load_plan(DirEncrypt);
    send_digram(ltr("A"), ltr("B"), 1'b0);
    send_digram(ltr("E"), ltr("E"), 1'b0);
    send_digram(ltr("A"), ltr("V"), 1'b0);
    send_digram(ltr("A"), ltr("Z"), 1'b0);
    send_digram(ltr("H"), ltr("Q"), 1'b0);
    send_digram(ltr("J"), ltr("A"), 1'b0);
    send_digram(ltr("A"), letter_t'(TopCode), 1'b0);
    send_digram(ltr("K"), ltr("A"), 1'b1);
    send_digram(ltr("Z"), ltr("Z"), 1'b1);
  endtask

  // Same square, decrypting: shifts go left and up, pad is ignored.
  task automatic test_standard_decrypt();
    load_plan(DirDecrypt);
    send_digram(ltr("A"), ltr("B"), 1'b0);
    send_digram(ltr("A"), ltr("V"), 1'b0);
    send_digram(ltr("H"), ltr("Q"), 1'b0);
    send_digram(ltr("B"), ltr("C"), 1'b1);
    send_digram(ltr("A"), ltr("A"), 1'b0);
    send_digram(ltr("Y"), letter_t'(LetterCount), 1'b0);
  endtask

  // A repeated letter and an unmatchable code, reached as a shift target.
  task automatic test_odd_cells();
    plan_alphabet(ltr("J"));
    square_plan[1] = letter_t'(TopCode - 1);
    square_plan[7] = ltr("A");
    load_plan(DirEncrypt);
    send_digram(ltr("A"), ltr("H"), 1'b0);
    send_digram(ltr("A"), ltr("D"), 1'b0);
    load_plan(DirDecrypt);
    send_digram(ltr("C"), ltr("D"), 1'b0);
    send_digram(ltr("G"), ltr("L"), 1'b0);
  endtask

  // Mostly shuffled 25-letter squares, some scrambled ones, plus the all-zero
  // and all-ones register extremes. Some phases run with no gaps at all.
  task automatic test_random_keys();
    int items;
    logic dir;
    for (int phase = 0; phase < 12; phase++) begin
      dir = 1'($urandom_range(0, 1));
      items = 140;
      if (phase == 0) begin
        fill_plan('0);
        dir = DirEncrypt;
        items = 30;
      end else if (phase == 1) begin
        fill_plan(letter_t'(TopCode));
        dir = DirDecrypt;
        items = 30;
      end else if (phase % 4 == 3) begin
        scramble_plan();
      end else begin
        plan_alphabet(letter_t'($urandom_range(0, LetterCount - 1)));
        shuffle_plan();
      end
      idle_on = (phase % 3 != 2);
      load_plan(dir);
      for (int n = 0; n < items; n++) begin
        // Pause mid-phase on odd phases until the pipe is empty.
        if (phase % 2 == 1 && n == items / 2) drain_pairs();
        send_digram(pick_letter(), pick_letter(), $urandom_range(0, 3) == 0);
      end
    end
  endtask

  // Compare each result beat with the oldest owed pair.
  always @(posedge clk) begin : check_result
    digram_t want;
    if (!rst && done === 1'b1) begin
      results_seen++;
      if (letter_error === 1'b1) flagged_count++;
      if (expected_digrams.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected beat, expected none, got first %0d second %0d error %0b",
                 $time, out_first, out_second, letter_error);
      end else begin
        want = expected_digrams.pop_front();
        if (out_first !== want.first) begin
          mismatch_count++;
          $display("%0t: out_first expected %0d, got %0d", $time, want.first, out_first);
        end
        if (out_second !== want.second) begin
          mismatch_count++;
          $display("%0t: out_second expected %0d, got %0d", $time, want.second, out_second);
        end
        if (letter_error !== want.error) begin
          mismatch_count++;
          $display("%0t: letter_error expected %0b, got %0b", $time, want.error,
                   letter_error);
        end
      end
    end
  end

  initial begin
    foreach (key_cells[k]) key_cells[k] = '0;
    decrypt_mode = DirEncrypt;
    repeat (10) @(negedge clk);
    rst = 1'b0;
    test_reset_square();
    test_standard_encrypt();
    test_standard_decrypt();
    test_odd_cells();
    test_random_keys();
    drain_pairs();
    $display("Checked %0d of %0d pairs over %0d square loads in both directions,",
             results_seen, pairs_sent, settings_loaded);
    $display("%0d of them flagged as holding a letter missing from the square.",
             flagged_count);
    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #3_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
